// ===== hdl/repp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repp_pkg
// Shared widths and divider request/response types for the equal pair
// probability block.
// ----------------------------------------------------------------------------
package repp_pkg;

  localparam int ARRAY_DEPTH = 65536;
  localparam int VALUE_RANGE = 65536;
  localparam int ADDR_W      = $clog2(ARRAY_DEPTH);
  localparam int VAL_W       = $clog2(VALUE_RANGE);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int PAIR_W      = 32;
  localparam int OUT_W       = 31;

  // divider request
  typedef struct packed {
    logic              start;
    logic [PAIR_W-1:0] dividend;
    logic [PAIR_W-1:0] divisor;
  } div_req_t;

  // divider response
  typedef struct packed {
    logic              done;
    logic [PAIR_W-1:0] quot;
    logic [PAIR_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hdl/repp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repp_div
// Restoring divider, one quotient bit per cycle; done pulses when the
// quotient and remainder are ready.
// ----------------------------------------------------------------------------
module repp_div
  import repp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(PAIR_W + 1);

  logic [PAIR_W-1:0] q_r, r_r, d_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [PAIR_W:0]   shifted;
  logic [PAIR_W:0]   trial;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {r_r, q_r[PAIR_W-1]};
    trial   = shifted - {1'b0, d_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= CW'(PAIR_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r <= req.dividend;
      r_r <= '0;
      d_r <= req.divisor;
    end else if (cnt_r != '0) begin
      if (trial[PAIR_W]) begin
        r_r <= shifted[PAIR_W-1:0];
        q_r <= {q_r[PAIR_W-2:0], 1'b0};
      end else begin
        r_r <= trial[PAIR_W-1:0];
        q_r <= {q_r[PAIR_W-2:0], 1'b1};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

endmodule

// ===== hdl/range_equal_pair_probability.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_equal_pair_probability
// Sliding window equal pair counter with gcd reduced probability output.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_cmd 0 writes in_value at in_position,
// in_cmd 1 queries [in_range_left, in_range_right]. One request at a time:
// in_ready is high only while the sequencer is idle.
// A write outside the window is checked and stored; inside it, the count
// of the old value is dropped and that of the new value added first.
// A query moves the window ends one position per step; each step is an
// element read, count read, count update and next move. Then the number
// of all pairs, len*(len-1)/2, is formed, and unless it or the equal pair
// count is zero, a Euclid loop plus two divisions run on one shared divider.
// Output channel (out_valid/out_ready): one result per query, none per
// write. The result sits in an output register, so a new request can be
// taken while the receiver stalls; a second query waits before output.
// Reset: after rst_n the count memory is cleared, one entry per cycle, and
// in_ready stays low until every entry is cleared.
// ----------------------------------------------------------------------------
module range_equal_pair_probability
  import repp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [15:0]       in_position,
  input  logic [15:0]       in_value,
  input  logic [15:0]       in_range_left,
  input  logic [15:0]       in_range_right,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_numerator,
  output logic [OUT_W-1:0]  out_denominator,
  output logic              out_bad_range
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_WCHK   = 5'd2;
  localparam logic [4:0] S_WSTORE = 5'd3;
  localparam logic [4:0] S_MOVE   = 5'd4;
  localparam logic [4:0] S_ELEM   = 5'd5;
  localparam logic [4:0] S_CNT    = 5'd6;
  localparam logic [4:0] S_WCNT   = 5'd7;
  localparam logic [4:0] S_UPD    = 5'd8;
  localparam logic [4:0] S_ALL    = 5'd9;
  localparam logic [4:0] S_ALL2   = 5'd10;
  localparam logic [4:0] S_GCD    = 5'd11;
  localparam logic [4:0] S_GWAIT  = 5'd12;
  localparam logic [4:0] S_NUM    = 5'd13;
  localparam logic [4:0] S_NWAIT  = 5'd14;
  localparam logic [4:0] S_DEN    = 5'd15;
  localparam logic [4:0] S_DWAIT  = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  localparam logic [1:0] PH_QUERY = 2'd0;
  localparam logic [1:0] PH_DROP  = 2'd1;
  localparam logic [1:0] PH_ADD   = 2'd2;

  localparam logic [VAL_W:0] LAST_ADDR = (VAL_W+1)'(VALUE_RANGE - 1);

  logic [4:0]          state_r, state_nxt;
  logic [VAL_W:0]      clr_r, clr_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic                add_r, add_nxt;
  logic [ADDR_W-1:0]   step_addr_r, step_addr_nxt;
  logic [ADDR_W-1:0]   ws_r, ws_nxt;
  logic [ADDR_W:0]     we_r, we_nxt;
  logic [PAIR_W-1:0]   pair_r, pair_nxt;
  logic                cmd_r;
  logic [ADDR_W-1:0]   pos_r, lo_r, hi_r;
  logic [VAL_W-1:0]    val_r;
  logic [VAL_W-1:0]    cval_r;
  logic                bad_r;
  logic [2*CNT_W-1:0]  prod_r;
  logic [PAIR_W-1:0]   all_r, a_r, b_r, num_r, den_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_num_r, out_den_r;
  logic                out_bad_r;

  logic [VAL_W-1:0]    elem_mem [ARRAY_DEPTH];
  logic [CNT_W-1:0]    cnt_mem  [VALUE_RANGE];
  logic [VAL_W-1:0]    elem_q;
  logic [CNT_W-1:0]    cnt_q;

  logic                accept;
  logic [CNT_W-1:0]    len;
  logic [ADDR_W:0]     end_excl;
  logic                cnt_we;
  logic [VAL_W-1:0]    cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata;
  div_req_t            dreq;
  div_rsp_t            drsp;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign len      = {1'b0, hi_r} - {1'b0, lo_r} + 1'b1;
  assign end_excl = {1'b0, hi_r} + 1'b1;

  repp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // divider requests
  always_comb begin
    dreq.start    = (state_r == S_GCD && b_r != '0) || state_r == S_NUM ||
                    state_r == S_DEN;
    dreq.dividend = (state_r == S_NUM) ? pair_r : (state_r == S_DEN) ? all_r : a_r;
    dreq.divisor  = (state_r == S_GCD) ? b_r : a_r;
  end

  // count memory port selection
  always_comb begin
    cnt_raddr = (state_r == S_WCNT) ? val_r : elem_q;
    cnt_we    = 1'b0;
    cnt_waddr = cval_r;
    cnt_wdata = cnt_q + 1'b1;
    if (state_r == S_CLR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_r[VAL_W-1:0];
      cnt_wdata = '0;
    end else if (state_r == S_UPD) begin
      if (add_r) begin
        cnt_we = 1'b1;
      end else begin
        cnt_we    = (cnt_q != '0);
        cnt_wdata = cnt_q - 1'b1;
      end
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (state_r == S_CNT || state_r == S_WCNT) cnt_q <= cnt_mem[cnt_raddr];
  end

  // element memory
  always_ff @(posedge clk) begin
    if (state_r == S_WSTORE) elem_mem[pos_r] <= val_r;
    if (state_r == S_ELEM) elem_q <= elem_mem[step_addr_r];
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    phase_nxt     = phase_r;
    add_nxt       = add_r;
    step_addr_nxt = step_addr_r;
    ws_nxt        = ws_r;
    we_nxt        = we_r;
    pair_nxt      = pair_r;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = in_cmd ? S_MOVE : S_WCHK;
        if (accept && in_cmd && in_range_left > in_range_right) state_nxt = S_OUT;
        phase_nxt = PH_QUERY;
      end
      S_WCHK: begin
        // write inside the window swaps the old value for the new
        if (pos_r >= ws_r && {1'b0, pos_r} < we_r) begin
          state_nxt     = S_ELEM;
          phase_nxt     = PH_DROP;
          add_nxt       = 1'b0;
          step_addr_nxt = pos_r;
        end else begin
          state_nxt = S_WSTORE;
        end
      end
      S_WSTORE: state_nxt = S_IDLE;
      S_MOVE: begin
        // grow first, then shrink
        state_nxt = S_ELEM;
        if (ws_r > lo_r) begin
          ws_nxt        = ws_r - 1'b1;
          step_addr_nxt = ws_r - 1'b1;
          add_nxt       = 1'b1;
        end else if (we_r < end_excl) begin
          step_addr_nxt = we_r[ADDR_W-1:0];
          we_nxt        = we_r + 1'b1;
          add_nxt       = 1'b1;
        end else if (ws_r < lo_r) begin
          step_addr_nxt = ws_r;
          ws_nxt        = ws_r + 1'b1;
          add_nxt       = 1'b0;
        end else if (we_r > end_excl) begin
          we_nxt        = we_r - 1'b1;
          step_addr_nxt = ADDR_W'(we_r - 1'b1);
          add_nxt       = 1'b0;
        end else begin
          state_nxt = S_ALL;
        end
      end
      S_ELEM: state_nxt = S_CNT;
      S_CNT:  state_nxt = S_UPD;
      S_WCNT: state_nxt = S_UPD;
      S_UPD: begin
        if (add_r) begin
          pair_nxt = pair_r + PAIR_W'(cnt_q);
        end else if (cnt_q != '0) begin
          pair_nxt = pair_r - PAIR_W'(cnt_q - 1'b1);
        end
        case (phase_r)
          PH_DROP: begin
            state_nxt = S_WCNT;
            phase_nxt = PH_ADD;
            add_nxt   = 1'b1;
          end
          PH_ADD:  state_nxt = S_WSTORE;
          default: state_nxt = S_MOVE;
        endcase
      end
      S_ALL:  state_nxt = S_ALL2;
      S_ALL2: state_nxt = (prod_r[PAIR_W:1] == '0 || pair_r == '0) ? S_OUT : S_GCD;
      S_GCD:  state_nxt = (b_r == '0) ? S_NUM : S_GWAIT;
      S_GWAIT: if (drsp.done) state_nxt = S_GCD;
      S_NUM:  state_nxt = S_NWAIT;
      S_NWAIT: if (drsp.done) state_nxt = S_DEN;
      S_DEN:  state_nxt = S_DWAIT;
      S_DWAIT: if (drsp.done) state_nxt = S_OUT;
      S_OUT: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      phase_r <= PH_QUERY;
      add_r   <= 1'b0;
      ws_r    <= '0;
      we_r    <= '0;
      pair_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      phase_r <= phase_nxt;
      add_r   <= add_nxt;
      ws_r    <= ws_nxt;
      we_r    <= we_nxt;
      pair_r  <= pair_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    step_addr_r <= step_addr_nxt;
    if (accept) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_value;
      lo_r  <= in_range_left;
      hi_r  <= in_range_right;
      bad_r <= in_cmd && (in_range_left > in_range_right);
      num_r <= '0;
      den_r <= '0;
    end
    if (state_r == S_CNT) cval_r <= elem_q;
    if (state_r == S_WCNT) cval_r <= val_r;
    if (state_r == S_ALL) prod_r <= len * (len - 1'b1);
    if (state_r == S_ALL2) begin
      all_r <= prod_r[PAIR_W:1];
      a_r   <= pair_r;
      b_r   <= prod_r[PAIR_W:1];
      num_r <= '0;
      den_r <= PAIR_W'(1);
    end
    if (state_r == S_GWAIT && drsp.done) begin
      a_r <= b_r;
      b_r <= drsp.rem;
    end
    if (state_r == S_NWAIT && drsp.done) num_r <= drsp.quot;
    if (state_r == S_DWAIT && drsp.done) den_r <= drsp.quot;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= cmd_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_num_r <= num_r[OUT_W-1:0];
      out_den_r <= den_r[OUT_W-1:0];
      out_bad_r <= bad_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_numerator   = out_num_r;
  assign out_denominator = out_den_r;
  assign out_bad_range   = out_bad_r;

endmodule

// ===== hdl/repp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repp_checker
// Port level checks for the equal pair probability block.
// ----------------------------------------------------------------------------
module repp_checker
  import repp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] out_numerator,
  input logic [OUT_W-1:0] out_denominator,
  input logic             out_bad_range
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_numerator) &&
    $stable(out_denominator) && $stable(out_bad_range))
    else $error("stalled result changed");

  // reversed range carries zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_range |-> out_numerator == '0 && out_denominator == '0)
    else $error("bad range with non-zero fields");

  // a proper result never has a zero denominator
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_range |-> out_denominator != '0)
    else $error("zero denominator");

  // one request in flight: ready drops after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // nothing offered straight after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity after reset");

endmodule

bind range_equal_pair_probability repp_checker u_repp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_numerator   (out_numerator),
  .out_denominator (out_denominator),
  .out_bad_range   (out_bad_range)
);

// ===== sim/range_equal_pair_probability_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_equal_pair_probability_tb
// Drives element writes and range queries into the equal pair probability
// block and checks every answer against a software copy of the window,
// the per-value counts and the gcd reduction. Queries stay inside a
// region that is fully written first, so no unwritten element is read.
// ----------------------------------------------------------------------------
module range_equal_pair_probability_tb;
  import repp_pkg::*;

  localparam bit CMD_WRITE  = 1'b0;
  localparam bit CMD_QUERY  = 1'b1;
  localparam int REGION     = 64;         // positions 0..REGION-1 are queried
  localparam int CYCLE_CAP  = 3000000;
  localparam int DRAIN_WAIT = 2000;

  typedef struct {
    logic [OUT_W-1:0] numerator;
    logic [OUT_W-1:0] denominator;
    logic             bad_range;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_cmd = CMD_WRITE;
  logic [15:0]      in_position = '0;
  logic [15:0]      in_value = '0;
  logic [15:0]      in_range_left = '0;
  logic [15:0]      in_range_right = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] out_numerator;
  logic [OUT_W-1:0] out_denominator;
  logic             out_bad_range;

  // shadow state of the block
  logic [15:0]      shadow_elems [int];
  int unsigned      shadow_counts [int];
  int unsigned      win_first;
  int unsigned      win_end;
  longint unsigned  pair_count;

  answer_t          pending_answers [$];
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               fail_count = 0;
  int               cycle_count = 0;

  range_equal_pair_probability i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .in_range_left   (in_range_left),
    .in_range_right  (in_range_right),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_numerator   (out_numerator),
    .out_denominator (out_denominator),
    .out_bad_range   (out_bad_range)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned count_of(int unsigned v);
    return shadow_counts.exists(v) ? shadow_counts[v] : 0;
  endfunction

  function automatic void count_in(logic [15:0] v);
    pair_count += count_of(v);
    shadow_counts[v] = count_of(v) + 1;
  endfunction

  function automatic void count_out(logic [15:0] v);
    if (count_of(v) != 0) begin
      shadow_counts[v] = count_of(v) - 1;
      pair_count -= shadow_counts[v];
    end
  endfunction

  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // update shadow state for one accepted request, queue the answer if any
  function automatic void track_request(logic cmd, logic [15:0] pos, logic [15:0] val,
                                        logic [15:0] lft, logic [15:0] rgt);
    answer_t         ans;
    int unsigned     lo;
    int unsigned     stop;
    longint unsigned span;
    longint unsigned all_pairs;
    longint unsigned g;
    if (cmd == CMD_WRITE) begin
      if (pos >= win_first && pos < win_end) begin
        count_out(shadow_elems.exists(pos) ? shadow_elems[pos] : 16'd0);
        count_in(val);
      end
      shadow_elems[pos] = val;
      return;
    end
    ans.numerator   = '0;
    ans.denominator = '0;
    ans.bad_range   = 1'b0;
    if (lft > rgt) begin
      ans.bad_range = 1'b1;
      pending_answers.push_back(ans);
      return;
    end
    lo   = lft;
    stop = rgt + 1;
    // grow before shrinking
    while (win_first > lo) begin
      win_first--;
      count_in(shadow_elems[win_first]);
    end
    while (win_end < stop) begin
      count_in(shadow_elems[win_end]);
      win_end++;
    end
    while (win_first < lo) begin
      count_out(shadow_elems[win_first]);
      win_first++;
    end
    while (win_end > stop) begin
      win_end--;
      count_out(shadow_elems[win_end]);
    end
    span      = stop - lo;
    all_pairs = span * (span - 1) / 2;
    if (all_pairs == 0 || pair_count == 0) begin
      ans.denominator = OUT_W'(1);
    end else begin
      g               = euclid_gcd(pair_count, all_pairs);
      ans.numerator   = OUT_W'(pair_count / g);
      ans.denominator = OUT_W'(all_pairs / g);
    end
    pending_answers.push_back(ans);
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result num=%0d den=%0d bad=%0b",
               out_numerator, out_denominator, out_bad_range);
        fail_count++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_numerator !== exp_ans.numerator) begin
          $error("numerator: expected %0d, got %0d", exp_ans.numerator, out_numerator);
          fail_count++;
        end
        if (out_denominator !== exp_ans.denominator) begin
          $error("denominator: expected %0d, got %0d", exp_ans.denominator,
                 out_denominator);
          fail_count++;
        end
        if (out_bad_range !== exp_ans.bad_range) begin
          $error("bad_range: expected %0b, got %0b", exp_ans.bad_range, out_bad_range);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // send one request; called and returns at a rising edge
  task automatic send_request(logic cmd, logic [15:0] pos, logic [15:0] val,
                              logic [15:0] lft, logic [15:0] rgt);
    bit taken;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_position    <= pos;
    in_value       <= val;
    in_range_left  <= lft;
    in_range_right <= rgt;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    track_request(cmd, pos, val, lft, rgt);
  endtask

  task automatic write_elem(int unsigned pos, int unsigned val);
    send_request(CMD_WRITE, pos[15:0], val[15:0], 16'($urandom), 16'($urandom));
  endtask

  task automatic ask_range(int unsigned lft, int unsigned rgt);
    send_request(CMD_QUERY, 16'($urandom), 16'($urandom), lft[15:0], rgt[15:0]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_answers.size() != 0);
    @(posedge clk);
  endtask

  // fill the queried region, plus the far end of the array
  task automatic test_fill_region();
    for (int p = 0; p < REGION; p++) write_elem(p, $urandom_range(0, 7));
    write_elem(65535, 65535);
    write_elem(0, 0);
    write_elem(3, 65535);
  endtask

  // single element, reversed, all equal, no pairs, in-window write
  task automatic test_special_ranges();
    ask_range(5, 5);
    ask_range(10, 3);
    ask_range(65535, 0);
    for (int p = 8; p < 12; p++) write_elem(p, 9);
    ask_range(8, 11);
    for (int p = 20; p < 24; p++) write_elem(p, 100 + p);
    ask_range(20, 23);
    ask_range(0, REGION - 1);
    write_elem(30, 65535);
    write_elem(31, 65535);
    ask_range(0, REGION - 1);
    ask_range(40, 45);
    ask_range(2, 6);
    wait_drained();
  endtask

  // mixed random traffic, mostly well-formed queries within the region
  task automatic test_random_traffic(int n_items);
    int unsigned sel;
    int unsigned lo;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        write_elem($urandom_range(0, REGION - 1), $urandom_range(0, 11));
      end else if (sel < 38) begin
        write_elem($urandom_range(0, REGION - 1), $urandom);
      end else if (sel < 45) begin
        write_elem($urandom_range(REGION, 65535), $urandom);
      end else if (sel < 52) begin
        lo = $urandom_range(1, 65535);
        ask_range(lo, $urandom_range(0, lo - 1));
      end else begin
        lo = $urandom_range(0, REGION - 1);
        ask_range(lo, $urandom_range(lo, ($urandom_range(0, 3) == 0) ? REGION - 1 :
                                         ((lo + 12 < REGION) ? lo + 12 : REGION - 1)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_region();
    test_special_ranges();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_traffic(140);
    send_idle_pct = 68; recv_stall_pct = 0;  test_random_traffic(140);
    send_idle_pct = 0;  recv_stall_pct = 68; test_random_traffic(140);
    wait_drained();
    send_idle_pct = 17; recv_stall_pct = 17; test_random_traffic(140);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_traffic(140);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0 && cycle_count < CYCLE_CAP) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
